// File: rtl/core/camera_follow_dead_zone_leash_assert.svh
// assertion macros shared by the checker of camera_follow_dead_zone_leash
// depends on clk and arst_n being visible where a macro is used
`ifndef CAMERA_FOLLOW_DEAD_ZONE_LEASH_ASSERT_SVH
`define CAMERA_FOLLOW_DEAD_ZONE_LEASH_ASSERT_SVH

// implication checked at every clock edge outside reset
`define CFDL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfdl assertion failed");

// invariant checked at every clock edge outside reset
`define CFDL_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("cfdl invariant failed");

`endif

// File: rtl/core/cfdl_pkg.sv
// types, widths and codes for the camera follow pipeline
// no dependencies
package cfdl_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CFG_W = 31;
	localparam int T_W = 33;               // centred target
	localparam int D_W = 34;               // signed delta
	localparam int M_W = D_W - 1;          // delta magnitude
	localparam int SQ_W = 2 * M_W + 1;     // sum of squares
	localparam int R_W = (SQ_W + 1) / 2;   // root bits
	localparam int Q_W = FRAC_BITS + 1;    // unit component magnitude
	localparam int N_W = M_W + FRAC_BITS;  // divider numerator
	localparam int P_W = 32;               // scaled length
	localparam int S_W = 35;               // final sum before saturation
	localparam int LATENCY = 4 + R_W + Q_W + 3;

	typedef enum logic [1:0] {
		ACT_HOLD  = 2'd0,
		ACT_STEP  = 2'd1,
		ACT_LEASH = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		REG_DEAD_ZONE    = 3'd0,
		REG_STEP_SPEED   = 3'd1,
		REG_LEASH_LENGTH = 3'd2,
		REG_VIEW_WIDTH   = 3'd3,
		REG_VIEW_HEIGHT  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] camera_x;
		logic signed [31:0] camera_y;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] next_x;
		logic signed [31:0] next_y;
		act_t               action;
	} out_beat_t;

	typedef struct packed {
		logic [CFG_W-1:0] dead_zone;
		logic [CFG_W-1:0] step_speed;
		logic [CFG_W-1:0] leash_length;
		logic [CFG_W-1:0] view_width;
		logic [CFG_W-1:0] view_height;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0]  cx;
		logic signed [31:0]  cy;
		logic signed [T_W-1:0] tx;
		logic signed [T_W-1:0] ty;
		logic                sx;
		logic                sy;
		logic [M_W-1:0]      ax;
		logic [M_W-1:0]      ay;
	} side_t;

	typedef struct packed {
		side_t          side;
		logic [R_W-1:0] span;
	} div_side_t;

endpackage

// File: rtl/core/cfdl_front.sv
// front stages: centring, delta, magnitudes, squares and their sum
// depends on cfdl_pkg
module cfdl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  cfdl_pkg::in_beat_t in_beat,
	input  cfdl_pkg::cfg_t    cfg,
	output logic              out_valid,
	output logic [cfdl_pkg::SQ_W-1:0] sum_sq,
	output cfdl_pkg::side_t   side
);
	import cfdl_pkg::*;

	logic                   v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0]     cx_s1, cy_s1;
	logic signed [T_W-1:0]  tx_s1, ty_s1;
	side_t                  sd_s2, sd_s3, sd_s4;
	logic signed [D_W-1:0]  dx, dy;
	logic [2*M_W-1:0]       sqx_s3, sqy_s3;
	logic [SQ_W-1:0]        sum_s4;

	assign dx = D_W'(tx_s1) - D_W'(cx_s1);
	assign dy = D_W'(ty_s1) - D_W'(cy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1 <= in_beat.camera_x;
		cy_s1 <= in_beat.camera_y;
		tx_s1 <= T_W'(in_beat.goal_x) - $signed({3'b000, cfg.view_width[CFG_W-1:1]});
		ty_s1 <= T_W'(in_beat.goal_y) - $signed({3'b000, cfg.view_height[CFG_W-1:1]});
		sd_s2.cx <= cx_s1;
		sd_s2.cy <= cy_s1;
		sd_s2.tx <= tx_s1;
		sd_s2.ty <= ty_s1;
		sd_s2.sx <= dx[D_W-1];
		sd_s2.sy <= dy[D_W-1];
		sd_s2.ax <= dx[D_W-1] ? M_W'(-dx) : M_W'(dx);
		sd_s2.ay <= dy[D_W-1] ? M_W'(-dy) : M_W'(dy);
		sd_s3 <= sd_s2;
		sqx_s3 <= sd_s2.ax * sd_s2.ax;
		sqy_s3 <= sd_s2.ay * sd_s2.ay;
		sd_s4 <= sd_s3;
		sum_s4 <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
	end

	assign out_valid = v_s4;
	assign sum_sq = sum_s4;
	assign side = sd_s4;

endmodule

// File: rtl/core/cfdl_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on cfdl_pkg
module cfdl_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [cfdl_pkg::SQ_W-1:0] radicand,
	input  cfdl_pkg::side_t   in_side,
	output logic              out_valid,
	output cfdl_pkg::div_side_t out_side
);
	import cfdl_pkg::*;

	localparam int RM_W = R_W + 2;

	logic              v_s    [0:R_W];
	logic [RM_W-1:0]   rem_s  [0:R_W];
	logic [R_W-1:0]    root_s [0:R_W];
	logic [2*R_W-1:0]  rad_s  [0:R_W];
	side_t             sd_s   [0:R_W];

	assign v_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = (2*R_W)'(radicand);
	assign sd_s[0] = in_side;

	for (genvar j = 0; j < R_W; j++) begin : g_stage
		logic [RM_W-1:0] shifted, trial;
		logic            take;

		assign shifted = {rem_s[j][RM_W-3:0], rad_s[j][2*R_W-1 -: 2]};
		assign trial = {root_s[j], 2'b01};
		assign take = shifted >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= take ? shifted - trial : shifted;
			root_s[j+1] <= {root_s[j][R_W-2:0], take};
			rad_s[j+1] <= {rad_s[j][2*R_W-3:0], 2'b00};
			sd_s[j+1] <= sd_s[j];
		end
	end

	assign out_valid = v_s[R_W];
	assign out_side.side = sd_s[R_W];
	assign out_side.span = root_s[R_W];

endmodule

// File: rtl/core/cfdl_div.sv
// pipelined restoring divider for both unit components, one quotient bit per stage
// depends on cfdl_pkg
module cfdl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cfdl_pkg::div_side_t in_side,
	output logic                out_valid,
	output cfdl_pkg::div_side_t out_side,
	output logic [cfdl_pkg::Q_W-1:0] qx,
	output logic [cfdl_pkg::Q_W-1:0] qy
);
	import cfdl_pkg::*;

	localparam int C_W = N_W + 1;

	logic        v_s   [0:Q_W];
	logic [N_W-1:0] rx_s [0:Q_W];
	logic [N_W-1:0] ry_s [0:Q_W];
	logic [Q_W-1:0] qx_s [0:Q_W];
	logic [Q_W-1:0] qy_s [0:Q_W];
	div_side_t   sd_s  [0:Q_W];

	assign v_s[0] = in_valid;
	assign rx_s[0] = {in_side.side.ax, {FRAC_BITS{1'b0}}};
	assign ry_s[0] = {in_side.side.ay, {FRAC_BITS{1'b0}}};
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign sd_s[0] = in_side;

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		localparam int B = Q_W - 1 - j;
		logic [C_W-1:0] trial;
		logic           tx_ok, ty_ok;

		assign trial = C_W'(sd_s[j].span) << B;
		assign tx_ok = {1'b0, rx_s[j]} >= trial;
		assign ty_ok = {1'b0, ry_s[j]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rx_s[j+1] <= tx_ok ? N_W'({1'b0, rx_s[j]} - trial) : rx_s[j];
			ry_s[j+1] <= ty_ok ? N_W'({1'b0, ry_s[j]} - trial) : ry_s[j];
			qx_s[j+1] <= {qx_s[j][Q_W-2:0], tx_ok};
			qy_s[j+1] <= {qy_s[j][Q_W-2:0], ty_ok};
			sd_s[j+1] <= sd_s[j];
		end
	end

	assign out_valid = v_s[Q_W];
	assign out_side = sd_s[Q_W];
	assign qx = qx_s[Q_W];
	assign qy = qy_s[Q_W];

endmodule

// File: rtl/core/cfdl_back.sv
// back stages: easing and leash decision, scaling multiply, final add with saturation
// depends on cfdl_pkg
module cfdl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cfdl_pkg::div_side_t in_side,
	input  logic [cfdl_pkg::Q_W-1:0] qx,
	input  logic [cfdl_pkg::Q_W-1:0] qy,
	input  cfdl_pkg::cfg_t      cfg,
	output logic                out_valid,
	output cfdl_pkg::out_beat_t out_beat
);
	import cfdl_pkg::*;

	logic                  v_b1, v_b2, v_b3;
	act_t                  act_b1, act_b2;
	logic [CFG_W-1:0]      len_b1;
	logic [Q_W-1:0]        qx_b1, qy_b1;
	logic signed [T_W-1:0] bx_b1, by_b1, bx_b2, by_b2;
	logic                  subx_b1, suby_b1, subx_b2, suby_b2;
	logic [P_W-1:0]        px_b2, py_b2;
	out_beat_t             res_b3;

	logic [R_W-1:0]        span;
	logic [CFG_W+1:0]      dz2, dz4;
	act_t                  act;
	logic [CFG_W-1:0]      speed;
	logic [Q_W+CFG_W-1:0]  prodx, prody;
	logic signed [S_W-1:0] sumx, sumy;

	assign span = in_side.span;
	assign dz2 = {1'b0, cfg.dead_zone, 1'b0};
	assign dz4 = {cfg.dead_zone, 2'b00};

	always_comb begin
		if (span <= R_W'(cfg.dead_zone)) begin
			act = ACT_HOLD;
		end else if (span > R_W'(cfg.leash_length)) begin
			act = ACT_LEASH;
		end else begin
			act = ACT_STEP;
		end
		if (span < R_W'(dz2)) begin
			speed = cfg.step_speed >> 2;
		end else if (span < R_W'(dz4)) begin
			speed = cfg.step_speed >> 1;
		end else begin
			speed = cfg.step_speed;
		end
	end

	assign prodx = qx_b1 * len_b1;
	assign prody = qy_b1 * len_b1;

	function automatic logic signed [31:0] sat32(input logic signed [S_W-1:0] v);
		logic signed [31:0] r;
		if (v > S_W'(32'sh7fffffff)) begin
			r = 32'sh7fffffff;
		end else if (v < -S_W'(33'sh080000000)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign sumx = act_b2 == ACT_HOLD ? S_W'(bx_b2) :
		subx_b2 ? S_W'(bx_b2) - $signed(S_W'(px_b2)) : S_W'(bx_b2) + $signed(S_W'(px_b2));
	assign sumy = act_b2 == ACT_HOLD ? S_W'(by_b2) :
		suby_b2 ? S_W'(by_b2) - $signed(S_W'(py_b2)) : S_W'(by_b2) + $signed(S_W'(py_b2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		act_b1 <= act;
		len_b1 <= act == ACT_LEASH ? cfg.leash_length : speed;
		qx_b1 <= qx;
		qy_b1 <= qy;
		bx_b1 <= act == ACT_LEASH ? in_side.side.tx : T_W'(in_side.side.cx);
		by_b1 <= act == ACT_LEASH ? in_side.side.ty : T_W'(in_side.side.cy);
		subx_b1 <= act == ACT_LEASH ? !in_side.side.sx : in_side.side.sx;
		suby_b1 <= act == ACT_LEASH ? !in_side.side.sy : in_side.side.sy;
		act_b2 <= act_b1;
		bx_b2 <= bx_b1;
		by_b2 <= by_b1;
		subx_b2 <= subx_b1;
		suby_b2 <= suby_b1;
		px_b2 <= prodx[FRAC_BITS +: P_W];
		py_b2 <= prody[FRAC_BITS +: P_W];
		res_b3.next_x <= sat32(sumx);
		res_b3.next_y <= sat32(sumy);
		res_b3.action <= act_b2;
	end

	assign out_valid = v_b3;
	assign out_beat = res_b3;

endmodule

// File: rtl/core/camera_follow_dead_zone_leash.sv
// top level of the dead-zone camera follow with easing and leash, plus its apb registers
// depends on cfdl_pkg, cfdl_front, cfdl_sqrt, cfdl_div, cfdl_back
//
// one query enters per clock, every clock: busy is always low and start is
// taken whenever it is high. each query leaves as one beat on done/result.
// the depth of the pipeline is set by the square root, which resolves one
// root bit per stage (34 stages), and the divider for the unit direction,
// one quotient bit per stage (17 stages). the receiver cannot stall the
// pipeline, so it must take every done beat. registers must be written over
// apb only while no query is in flight; the block does not enforce this.
module camera_follow_dead_zone_leash (
	input  logic               clk,
	input  logic               arst_n,
	// query channel
	input  logic               start,
	output logic               busy,
	input  cfdl_pkg::in_beat_t request,
	// result channel
	output logic               done,
	output cfdl_pkg::out_beat_t result,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import cfdl_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	logic      f_valid;
	logic [SQ_W-1:0] f_sum;
	side_t     f_side;
	logic      r_valid;
	div_side_t r_side;
	logic      d_valid;
	div_side_t d_side;
	logic [Q_W-1:0] d_qx, d_qy;

	// never stalls
	assign busy = 1'b0;
	assign pready = 1'b1;

	assign idx = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;

	// register file, writes to unused addresses fall away
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone <= '0;
			cfg_q.step_speed <= CFG_W'(1) << FRAC_BITS;
			cfg_q.leash_length <= '1;
			cfg_q.view_width <= '0;
			cfg_q.view_height <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_DEAD_ZONE:    cfg_q.dead_zone <= pwdata[CFG_W-1:0];
				REG_STEP_SPEED:   cfg_q.step_speed <= pwdata[CFG_W-1:0];
				REG_LEASH_LENGTH: cfg_q.leash_length <= pwdata[CFG_W-1:0];
				REG_VIEW_WIDTH:   cfg_q.view_width <= pwdata[CFG_W-1:0];
				REG_VIEW_HEIGHT:  cfg_q.view_height <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_DEAD_ZONE:    prdata = {1'b0, cfg_q.dead_zone};
			REG_STEP_SPEED:   prdata = {1'b0, cfg_q.step_speed};
			REG_LEASH_LENGTH: prdata = {1'b0, cfg_q.leash_length};
			REG_VIEW_WIDTH:   prdata = {1'b0, cfg_q.view_width};
			REG_VIEW_HEIGHT:  prdata = {1'b0, cfg_q.view_height};
			default:          prdata = '0;
		endcase
	end

	// centring, delta, squares
	cfdl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_beat   (request),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.sum_sq    (f_sum),
		.side      (f_side)
	);

	// distance
	cfdl_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.radicand  (f_sum),
		.in_side   (f_side),
		.out_valid (r_valid),
		.out_side  (r_side)
	);

	// unit direction
	cfdl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid),
		.in_side   (r_side),
		.out_valid (d_valid),
		.out_side  (d_side),
		.qx        (d_qx),
		.qy        (d_qy)
	);

	// easing, leash, output register
	cfdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_side   (d_side),
		.qx        (d_qx),
		.qy        (d_qy),
		.cfg       (cfg_q),
		.out_valid (done),
		.out_beat  (result)
	);

endmodule

// File: rtl/core/cfdl_checker.sv
// port-level checker for camera_follow_dead_zone_leash and its bind
// depends on cfdl_pkg and camera_follow_dead_zone_leash_assert.svh
`include "camera_follow_dead_zone_leash_assert.svh"

module cfdl_port_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  cfdl_pkg::in_beat_t  request,
	input  logic                done,
	input  cfdl_pkg::out_beat_t result,
	input  logic                pready
);
	import cfdl_pkg::*;

	`CFDL_ASSERT_ALWAYS(a_never_busy, !busy && pready)
	`CFDL_ASSERT_IMPL(a_beat_has_query, done, $past(start && !busy, LATENCY))
	`CFDL_ASSERT_IMPL(a_query_gives_beat, start && !busy, ##LATENCY done)
	`CFDL_ASSERT_IMPL(a_hold_keeps_camera, done && result.action == ACT_HOLD, result.next_x == $past(request.camera_x, LATENCY) && result.next_y == $past(request.camera_y, LATENCY))

endmodule

bind camera_follow_dead_zone_leash cfdl_port_checker u_cfdl_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result),
	.pready  (pready)
);

// File: tb/sv/cfdl_checker.sv
// checker for the camera follow block: predicts each query's beat and compares
// depends on cfdl_pkg; watches the query, result and register channels
module cfdl_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  cfdl_pkg::in_beat_t  request,
	input  logic                done,
	input  cfdl_pkg::out_beat_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending
);
	import cfdl_pkg::*;

	cfg_t cfg;
	out_beat_t follow_q[$];

	function automatic logic [63:0] root_floor(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int i = 35; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if ({64'd0, c} * {64'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// magnitude-based truncation toward zero, as the block does
	function automatic logic signed [63:0] unit_dir(logic signed [63:0] d, logic [63:0] len);
		logic [63:0] m;
		m = d < 0 ? -d : d;
		m = (m << FRAC_BITS) / len;
		return d < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] scaled(logic signed [63:0] u, logic [63:0] len);
		logic [63:0] m;
		m = u < 0 ? -u : u;
		m = (m * len) >> FRAC_BITS;
		return u < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic out_beat_t follow_step(in_beat_t q);
		out_beat_t o;
		logic signed [63:0] cx, cy, tx, ty, dx, dy, ux, uy, nx, ny;
		logic [63:0] ax, ay, span, speed, dz;
		cx = q.camera_x;
		cy = q.camera_y;
		tx = 64'(q.goal_x) - 64'(cfg.view_width >> 1);
		ty = 64'(q.goal_y) - 64'(cfg.view_height >> 1);
		dx = tx - cx;
		dy = ty - cy;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		span = root_floor({64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay});
		dz = cfg.dead_zone;
		if (span <= dz) begin
			nx = cx;
			ny = cy;
			o.action = ACT_HOLD;
		end else begin
			ux = unit_dir(dx, span);
			uy = unit_dir(dy, span);
			speed = cfg.step_speed;
			if (span < dz * 2)
				speed = speed >> 2;
			else if (span < dz * 4)
				speed = speed >> 1;
			if (span > 64'(cfg.leash_length)) begin
				nx = tx - scaled(ux, cfg.leash_length);
				ny = ty - scaled(uy, cfg.leash_length);
				o.action = ACT_LEASH;
			end else begin
				nx = cx + scaled(ux, speed);
				ny = cy + scaled(uy, speed);
				o.action = ACT_STEP;
			end
		end
		o.next_x = clamp32(nx);
		o.next_y = clamp32(ny);
		return o;
	endfunction

	assign pending = follow_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			cfg.dead_zone <= '0;
			cfg.step_speed <= 31'd65536;
			cfg.leash_length <= 31'h7fffffff;
			cfg.view_width <= '0;
			cfg.view_height <= '0;
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_DEAD_ZONE:    cfg.dead_zone <= pwdata[30:0];
					REG_STEP_SPEED:   cfg.step_speed <= pwdata[30:0];
					REG_LEASH_LENGTH: cfg.leash_length <= pwdata[30:0];
					REG_VIEW_WIDTH:   cfg.view_width <= pwdata[30:0];
					REG_VIEW_HEIGHT:  cfg.view_height <= pwdata[30:0];
					default: ;
				endcase
			end
			if (done) begin
				if (follow_q.size() == 0) begin
					$display("%0t unexpected beat: actual %h", $time, result);
					errors <= errors + 1;
				end else begin
					want = follow_q.pop_front();
					if (want.next_x !== result.next_x || want.next_y !== result.next_y
							|| want.action !== result.action) begin
						$display("%0t mismatch: expected x=%h y=%h a=%0d actual x=%h y=%h a=%0d",
							$time, want.next_x, want.next_y, want.action,
							result.next_x, result.next_y, result.action);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				follow_q.push_back(follow_step(request));
		end
	end
endmodule

// File: tb/sv/tb.sv
// testbench top for camera_follow_dead_zone_leash: clock, reset, stimulus, verdict
// depends on cfdl_pkg, cfdl_checker and the block itself
module tb;
	import cfdl_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_beat_t request;
	logic done;
	out_beat_t result;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int pending;
	int idle_cycles;

	camera_follow_dead_zone_leash dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cfdl_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with no query accepted, no beat and no register access
	always @(posedge clk) begin
		if ((start && !busy) || done || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// setup, access, then an idle gap so writes never overlap
	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
	endtask

	// one query; start stays high across back-to-back beats
	task automatic send_query(in_beat_t q);
		start <= 1;
		request <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// drain the pipeline before touching registers
	task automatic drain;
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9)
				: 32'h80000000 + $urandom_range(0, 9);
			default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
		endcase
	endfunction

	// a camera near the goal, so dead zone and easing thresholds get hit
	function automatic in_beat_t near_query(int spread);
		in_beat_t q;
		q.goal_x = rand_coord(2);
		q.goal_y = rand_coord(2);
		q.camera_x = q.goal_x + $signed($urandom_range(0, 2 * spread)) - spread;
		q.camera_y = q.goal_y + $signed($urandom_range(0, 2 * spread)) - spread;
		return q;
	endfunction

	function automatic in_beat_t rand_query();
		in_beat_t q;
		int m;
		m = $urandom_range(0, 9);
		if (m < 6)
			return near_query(1 << $urandom_range(4, 22));
		q.camera_x = rand_coord(m % 3);
		q.camera_y = rand_coord($urandom_range(0, 2));
		q.goal_x = rand_coord($urandom_range(0, 2));
		q.goal_y = rand_coord(m % 3);
		return q;
	endfunction

	task automatic random_phase(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && sent < count) begin
				send_query(rand_query());
				sent++;
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
	endtask

	initial begin
		in_beat_t q;
		arst_n = 0;
		start = 0;
		request = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero length, extremes, reset config
		send_query('0);
		send_query({32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000});
		send_query({32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
		send_query({32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
		send_query({32'hffffffff, 32'h0, 32'h0, 32'hffffffff});
		drain();

		// dead zone, easing bands and leash near thresholds
		reg_write(REG_DEAD_ZONE, 32'h0001_0000);
		reg_write(REG_STEP_SPEED, 32'h0004_0000);
		reg_write(REG_LEASH_LENGTH, 32'h0008_0000);
		reg_write(REG_VIEW_WIDTH, 32'h0002_0000);
		reg_write(REG_VIEW_HEIGHT, 32'h0002_0001);
		reg_write(reg_idx_t'(3'd7), 32'hffffffff);
		q = '0;
		q.goal_x = 32'h0001_0000;
		q.goal_y = 32'h0001_0000;
		send_query(q);
		q.goal_x = 32'h0002_0000;
		send_query(q);
		q.goal_x = 32'h0002_ffff;
		send_query(q);
		q.goal_x = 32'h0003_0000;
		send_query(q);
		q.goal_x = 32'h0004_ffff;
		send_query(q);
		q.goal_x = 32'h0005_0000;
		send_query(q);
		q.goal_x = 32'h0009_0000;
		send_query(q);
		q.goal_x = 32'h0040_0000;
		q.goal_y = 32'hffc0_0000;
		send_query(q);
		drain();

		// several register settings, extremes among them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_DEAD_ZONE, 32'h0);
					reg_write(REG_STEP_SPEED, 32'h7fffffff);
					reg_write(REG_LEASH_LENGTH, 32'h7fffffff);
					reg_write(REG_VIEW_WIDTH, 32'hffffffff);
					reg_write(REG_VIEW_HEIGHT, 32'h7fffffff);
				end
				1: begin
					reg_write(REG_DEAD_ZONE, 32'h7fffffff);
					reg_write(REG_VIEW_WIDTH, 32'h0);
					reg_write(REG_VIEW_HEIGHT, 32'h0);
				end
				2: begin
					reg_write(REG_DEAD_ZONE, 32'h0);
					reg_write(REG_LEASH_LENGTH, 32'h0);
					reg_write(REG_STEP_SPEED, 32'h0);
				end
				default: begin
					reg_write(REG_DEAD_ZONE, 1 << $urandom_range(4, 22));
					reg_write(REG_STEP_SPEED, $urandom() >> $urandom_range(0, 20));
					reg_write(REG_LEASH_LENGTH, 1 << $urandom_range(8, 30));
					reg_write(REG_VIEW_WIDTH, $urandom() >> $urandom_range(0, 20));
					reg_write(REG_VIEW_HEIGHT, $urandom() >> $urandom_range(0, 20));
				end
			endcase
			random_phase(190);
			drain();
		end

		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
